[design/ss_pkg.sv]
// Shared constants and types for the substring search block.
package ss_pkg;

  localparam int TEXT_MAX    = 1024;
  localparam int PATTERN_MAX = 8;

  localparam int IDX_W  = $clog2(TEXT_MAX) + 1;   // holds TEXT_MAX itself
  localparam int LEN_W  = 4;                      // pattern_length register
  localparam int CNT_W  = $clog2(PATTERN_MAX) + 1;
  localparam int POS_W  = 10;                     // start_position register
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_START_POSITION = 2'd2
  } reg_index_t;

  // Per-cycle control that every window cell sees.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[design/ss_if.sv]
// Valid/ready channels for text bytes and search results.
interface ss_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ss_result_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [ss_pkg::IDX_W-1:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

[design/ss_cell.sv]
// One window cell: holds a text byte, passes it on, compares the byte it takes.
module ss_cell (
  input  logic               clk,
  input  logic               rst,
  input  ss_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         d,
  input  logic [7:0]         want,
  input  logic               used,
  output logic [7:0]         q,
  output logic               hit
);

  // compare against the value this cell holds after the shift
  assign hit = !used || (d == want);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= d;
    end
  end

endmodule

[design/substring_search_core.sv]
// Top level of the streaming substring search: config regs, cell chain, result register.
// Latency: a result is valid on the cycle after the text beat that causes it.
// Throughput: one text byte per cycle while no result is stalled; the whole window compare runs in the
//   accept cycle across the chain of eight cells, so nothing iterates.
// A stalled result holds the input side off until it is taken.
// Reset (rst, synchronous, active high): window, byte index, match state and
//   result valid clear; pattern_bytes 0, pattern_length 1, start_position 0.
module substring_search_core (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ss_pkg::ADDR_W-1:0] paddr,
  input  logic [ss_pkg::DATA_W-1:0] pwdata,
  output logic [ss_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  // streams
  ss_text_if.sink                   text,
  ss_result_if.source               result
);

  localparam int NCELL = ss_pkg::PATTERN_MAX;

  // ---------------- configuration registers ----------------
  logic [ss_pkg::DATA_W-1:0] pattern_bytes;
  logic [ss_pkg::LEN_W-1:0]  pattern_length;
  logic [ss_pkg::POS_W-1:0]  start_position;
  logic                      cfg_write;
  ss_pkg::reg_index_t        cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // registers sit on 8-byte boundaries
  assign cfg_sel   = ss_pkg::reg_index_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= ss_pkg::LEN_W'(1);
      start_position <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        ss_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= pwdata;
        ss_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[ss_pkg::LEN_W-1:0];
        ss_pkg::REG_START_POSITION: start_position <= pwdata[ss_pkg::POS_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      ss_pkg::REG_PATTERN_BYTES:  prdata = pattern_bytes;
      ss_pkg::REG_PATTERN_LENGTH: prdata = ss_pkg::DATA_W'(pattern_length);
      ss_pkg::REG_START_POSITION: prdata = ss_pkg::DATA_W'(start_position);
      default:                    prdata = '0;
    endcase
  end

  // Effective pattern length: 0 acts as 1, anything over the window as full window.
  logic [ss_pkg::LEN_W-1:0] len_used;
  always_comb begin
    if (pattern_length == '0) begin
      len_used = ss_pkg::LEN_W'(1);
    end else if (pattern_length > ss_pkg::LEN_W'(NCELL)) begin
      len_used = ss_pkg::LEN_W'(NCELL);
    end else begin
      len_used = pattern_length;
    end
  end

  // ---------------- per-text state ----------------
  logic [ss_pkg::IDX_W-1:0] byte_index;
  logic [ss_pkg::CNT_W-1:0] bytes_considered;
  logic                     match_done;

  logic                     accept;
  logic                     search;
  logic [ss_pkg::CNT_W-1:0] considered_next;
  logic [ss_pkg::IDX_W-1:0] index_next;
  logic                     window_hit;
  logic                     hit;
  logic                     emit_miss;

  assign text.ready = !result.valid || result.ready;
  assign accept     = text.valid && text.ready;

  // A byte enters the window only before a match, inside the text limit and
  // at or past the start position.
  assign search = !match_done
               && (byte_index < ss_pkg::IDX_W'(ss_pkg::TEXT_MAX))
               && (byte_index >= ss_pkg::IDX_W'(start_position));

  assign considered_next = (search && bytes_considered < ss_pkg::CNT_W'(NCELL))
                         ? bytes_considered + 1'b1 : bytes_considered;

  assign index_next = (byte_index < ss_pkg::IDX_W'(ss_pkg::TEXT_MAX))
                    ? byte_index + 1'b1 : byte_index;

  // ---------------- cell chain ----------------
  // Cell 0 takes the new byte; cell k takes cell k-1's byte. Cell k is
  // compared with pattern byte len-1-k when k is inside the pattern.
  ss_pkg::cell_ctrl_t ctrl;
  logic [7:0]         cell_q   [NCELL];
  logic [7:0]         cell_d   [NCELL];
  logic [NCELL-1:0]   cell_hit;

  assign ctrl.shift = accept && search;
  assign ctrl.clear = accept && text.last_byte;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [ss_pkg::LEN_W-1:0] sel;
    logic [7:0]               want;
    logic                     used;

    assign sel  = len_used - 1'b1 - ss_pkg::LEN_W'(k);
    assign want = pattern_bytes[8*sel[2:0] +: 8];
    assign used = ss_pkg::LEN_W'(k) < len_used;

    if (k == 0) begin : g_head
      assign cell_d[k] = text.text_byte;
    end else begin : g_link
      assign cell_d[k] = cell_q[k-1];
    end

    ss_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .d    (cell_d[k]),
      .want (want),
      .used (used),
      .q    (cell_q[k]),
      .hit  (cell_hit[k])
    );
  end

  assign window_hit = &cell_hit;
  assign hit        = search && window_hit
                   && (considered_next >= ss_pkg::CNT_W'(len_used));
  // end of text with no match: report the (saturated) length
  assign emit_miss  = text.last_byte && !match_done && !hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      bytes_considered <= '0;
      match_done       <= 1'b0;
    end else if (accept) begin
      if (text.last_byte) begin
        byte_index       <= '0;
        bytes_considered <= '0;
        match_done       <= 1'b0;
      end else begin
        byte_index       <= index_next;
        bytes_considered <= considered_next;
        match_done       <= match_done || hit;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= hit || emit_miss;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (hit || emit_miss)) begin
      result.found          <= hit;
      result.match_position <= hit
                             ? byte_index + 1'b1 - ss_pkg::IDX_W'(len_used)
                             : index_next;
    end
  end

endmodule

[design/ss_chk.sv]
// Port-level checks for substring_search_core, attached by bind.
module ss_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     text_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic                     res_found,
  input logic [ss_pkg::IDX_W-1:0] res_position
);

  // a waiting result must hold (protocol)
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_position))
    else $error("result beat changed while stalled");

  // no new text beat may be taken while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !text_ready)
    else $error("text accepted over a stalled result");

  // a miss reports a length of at least one byte and at most the limit
  a_miss_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |->
      res_position != '0 && res_position <= ss_pkg::IDX_W'(ss_pkg::TEXT_MAX))
    else $error("miss length out of range");

  // a match starts inside the searchable text
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_found |-> res_position < ss_pkg::IDX_W'(ss_pkg::TEXT_MAX))
    else $error("match position out of range");

endmodule

bind substring_search_core ss_chk u_ss_chk (
  .clk          (clk),
  .rst          (rst),
  .text_ready   (text.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_found    (result.found),
  .res_position (result.match_position)
);
